>>> sv/bgf_pkg.sv
// Shared constants, types and tap table for the 5x5 box and Gaussian filter.
package bgf_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int WIN       = 5;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int EW        = ADDR_W + 1;
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 13;
    localparam int ROW_W     = HEIGHT_W + 1;
    localparam int QY_W      = ROW_W + 1;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 24;
    localparam int STACK_W   = (WIN - 1) * PIX_W;
    localparam int BOX_COL_W = 11;
    localparam int GAU_COL_W = 12;
    localparam int BOX_W     = 13;
    localparam int GAU_W     = 16;
    localparam int DIV25_SHIFT = 17;

    localparam logic [BOX_W-1:0]     DIV25_MUL    = 13'd5243;
    localparam logic [WIDTH_W-1:0]   RESET_WIDTH  = 12'd640;
    localparam logic [HEIGHT_W-1:0]  RESET_HEIGHT = 13'd480;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [2:0] TAPS [WIN] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

    typedef struct packed {
        logic              valid;
        logic              res;
        logic [ADDR_W-1:0] qx;
        logic              last;
    } t_ctrl;

    typedef struct packed {
        logic [2:0][BOX_COL_W-1:0] box;
        logic [2:0][GAU_COL_W-1:0] gau;
    } t_col_sums;

endpackage

>>> sv/bgf_in_if.sv
// Pixel input channel.
interface bgf_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, command, red_in, green_in, blue_in, input ready);
    modport sink (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

>>> sv/bgf_out_if.sv
// Filter result channel.
interface bgf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic [7:0] gauss_red;
    logic [7:0] gauss_green;
    logic [7:0] gauss_blue;
    logic       frame_end;

    modport source (output valid, avg_red, avg_green, avg_blue, gauss_red, gauss_green,
                    gauss_blue, frame_end, input ready);
    modport sink (input valid, avg_red, avg_green, avg_blue, gauss_red, gauss_green,
                  gauss_blue, frame_end, output ready);
endinterface

>>> sv/bgf_ram.sv
// Generic single-port-write, registered-read RAM.
module bgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/bgf_column.sv
// Stream position, line store and vertical column sums.
module bgf_column import bgf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_in_valid,
    input  logic                i_command,
    input  logic [PIX_W-1:0]    i_pixel,
    input  logic [EW-1:0]       i_width,
    input  logic [HEIGHT_W-1:0] i_height,
    output t_ctrl               o_ctrl,
    output t_col_sums           o_sums
);
    logic [ADDR_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic                r_a_valid;
    logic [PIX_W-1:0]    r_a_pix;
    logic [ADDR_W-1:0]   r_a_col;
    logic [ROW_W-1:0]    r_a_row;
    logic                r_a_res;
    logic [ADDR_W-1:0]   r_a_qx;
    logic                r_a_last;
    logic                r_a_fwd;
    logic [STACK_W-1:0]  r_a_fwd_data;

    logic signed [QY_W-1:0] s_qy;
    logic signed [QY_W-1:0] s_hgt;
    logic [EW:0]            s_qx_wide;
    logic [ADDR_W-1:0]      s_qx;
    logic                   s_res;
    logic                   s_last;
    logic                   s_wrap;
    logic [EW-1:0]          s_col_inc;
    logic [PIX_W-1:0]       s_store_pix;
    logic [STACK_W-1:0]     s_rdata;
    logic [STACK_W-1:0]     s_old;
    logic [STACK_W-1:0]     s_new;
    logic [PIX_W-1:0]       s_px [WIN];
    logic [WIN-1:0]         s_row_ok;

    always_comb begin
        s_hgt = $signed({2'b00, i_height});
        if (i_width == EW'(1)) begin
            s_qx_wide = '0;
            s_qy      = $signed({1'b0, r_row}) - $signed(QY_W'(4));
        end else if (r_col < ADDR_W'(2)) begin
            s_qx_wide = (EW+1)'(r_col) + (EW+1)'(i_width) - (EW+1)'(2);
            s_qy      = $signed({1'b0, r_row}) - $signed(QY_W'(3));
        end else begin
            s_qx_wide = (EW+1)'(r_col) - (EW+1)'(2);
            s_qy      = $signed({1'b0, r_row}) - $signed(QY_W'(2));
        end
        s_qx   = s_qx_wide[ADDR_W-1:0];
        s_res  = !s_qy[QY_W-1] && (s_qy < s_hgt);
        s_last = s_res && (s_qy == s_hgt - $signed(QY_W'(1)))
                 && ({1'b0, s_qx} == i_width - EW'(1));
        s_wrap = (!s_qy[QY_W-1] && (s_qy >= s_hgt)) || s_last;

        s_col_inc = {1'b0, r_col} + EW'(1);
        if (s_wrap) begin
            n_col = '0;
            n_row = '0;
        end else if (s_col_inc >= i_width) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = s_col_inc[ADDR_W-1:0];
            n_row = r_row;
        end

        if (({1'b0, r_col} < i_width) && (r_row < ROW_W'(i_height))
            && (i_command == CMD_PIXEL)) begin
            s_store_pix = i_pixel;
        end else begin
            s_store_pix = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_a_fwd   <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_in_valid;
            r_a_fwd   <= r_a_valid && (r_a_col == r_col);
            if (i_in_valid) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_fwd_data <= s_new;
            if (i_in_valid) begin
                r_a_pix  <= s_store_pix;
                r_a_col  <= r_col;
                r_a_row  <= r_row;
                r_a_res  <= s_res;
                r_a_qx   <= s_qx;
                r_a_last <= s_last;
            end
        end
    end

    bgf_ram #(
        .WIDTH (STACK_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (i_en && r_a_valid),
        .i_waddr (r_a_col),
        .i_wdata (s_new),
        .i_re    (i_en && i_in_valid),
        .i_raddr (r_col),
        .o_rdata (s_rdata)
    );

    always_comb begin
        s_old = r_a_fwd ? r_a_fwd_data : s_rdata;
        s_new = {s_old[STACK_W-PIX_W-1:0], r_a_pix};
        s_px[0] = r_a_pix;
        for (int k = 1; k < WIN; k++) begin
            s_px[k] = s_old[(k-1)*PIX_W +: PIX_W];
        end
        for (int k = 0; k < WIN; k++) begin
            s_row_ok[k] = ({1'b0, r_a_row} >= (ROW_W+1)'(k))
                          && ({1'b0, r_a_row} < (ROW_W+1)'(i_height) + (ROW_W+1)'(k));
        end
        o_sums = '0;
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < WIN; k++) begin
                if (s_row_ok[k]) begin
                    o_sums.box[c] = o_sums.box[c] + BOX_COL_W'(s_px[k][8*c +: 8]);
                    o_sums.gau[c] = o_sums.gau[c]
                                    + GAU_COL_W'(s_px[k][8*c +: 8]) * GAU_COL_W'(TAPS[k]);
                end
            end
        end
    end

    assign o_ctrl = '{valid: r_a_valid, res: r_a_res, qx: r_a_qx, last: r_a_last};

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_in_valid) |=> r_a_valid)
        else $error("accepted transfer did not reach stage A");

    a_row_zero_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == '0 && $past(r_row) != '0) |-> (r_col == '0))
        else $error("row wrapped without column reset");
endmodule

>>> sv/bgf_window.sv
// Five-column window, horizontal sums and result register.
module bgf_window import bgf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctrl         i_ctrl,
    input  t_col_sums     i_sums,
    input  logic [EW-1:0] i_width,
    output logic          o_valid,
    output logic [7:0]    o_avg [3],
    output logic [7:0]    o_gau [3],
    output logic          o_last
);
    t_col_sums r_cs [WIN];
    t_ctrl     r_b;
    logic       r_o_valid;
    logic [7:0] r_avg [3];
    logic [7:0] r_gau [3];
    logic       r_last;

    logic [WIN-1:0]       s_mask;
    logic [BOX_W-1:0]     s_box [3];
    logic [GAU_W-1:0]     s_gsum [3];
    logic [2*BOX_W-1:0]   s_prod [3];

    always_comb begin
        s_mask[0] = ((EW+1)'(r_b.qx) + (EW+1)'(2)) < (EW+1)'(i_width);
        s_mask[1] = ((EW+1)'(r_b.qx) + (EW+1)'(1)) < (EW+1)'(i_width);
        s_mask[2] = 1'b1;
        s_mask[3] = r_b.qx >= ADDR_W'(1);
        s_mask[4] = r_b.qx >= ADDR_W'(2);
        for (int c = 0; c < 3; c++) begin
            s_box[c]  = '0;
            s_gsum[c] = '0;
            for (int j = 0; j < WIN; j++) begin
                if (s_mask[j]) begin
                    s_box[c]  = s_box[c] + BOX_W'(r_cs[j].box[c]);
                    s_gsum[c] = s_gsum[c] + GAU_W'(r_cs[j].gau[c]) * GAU_W'(TAPS[j]);
                end
            end
            s_prod[c] = (2*BOX_W)'(s_box[c]) * (2*BOX_W)'(DIV25_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b       <= '0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_b       <= i_ctrl;
            r_o_valid <= r_b.valid && r_b.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ctrl.valid) begin
                for (int j = WIN - 1; j > 0; j--) begin
                    r_cs[j] <= r_cs[j-1];
                end
                r_cs[0] <= i_sums;
            end
            for (int c = 0; c < 3; c++) begin
                r_avg[c] <= s_prod[c][DIV25_SHIFT +: 8];
                r_gau[c] <= s_gsum[c][GAU_W-1 -: 8];
            end
            r_last <= r_b.last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_avg   = r_avg;
    assign o_gau   = r_gau;
    assign o_last  = r_last;

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_b.valid && r_b.res))
        else $error("result without a due item");
endmodule

>>> sv/box_and_gaussian_5x5_filter.sv
// Top level: 5x5 box average and binomial Gaussian over an RGB raster stream.
// A result passes through stage A, register B and the output register after the
// transfer that completes its window (two rows and two pixels behind the input).
// Throughput: one pixel per cycle; the pipeline stalls only on output backpressure.
// Reset (synchronous, active low) clears position, pipeline valids and sets
// width 640, height 480; line store contents are masked until written.
module box_and_gaussian_5x5_filter import bgf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bgf_in_if.sink               i_stream,
    bgf_out_if.source            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [EW-1:0]       s_width;
    logic [HEIGHT_W-1:0] s_height;
    logic                s_en;
    logic                s_valid;
    t_ctrl               s_ctrl;
    t_col_sums           s_sums;
    logic [7:0]          s_avg [3];
    logic [7:0]          s_gau [3];
    logic                s_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            s_width = EW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            s_width = EW'(MAX_WIDTH);
        end else begin
            s_width = EW'(r_width);
        end
        s_height = (r_height == '0) ? HEIGHT_W'(1) : r_height;
    end

    assign s_en           = !s_valid || o_result.ready;
    assign i_stream.ready = s_en;

    bgf_column u_column (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (s_en),
        .i_in_valid (i_stream.valid),
        .i_command  (i_stream.command),
        .i_pixel    ({i_stream.blue_in, i_stream.green_in, i_stream.red_in}),
        .i_width    (s_width),
        .i_height   (s_height),
        .o_ctrl     (s_ctrl),
        .o_sums     (s_sums)
    );

    bgf_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_ctrl  (s_ctrl),
        .i_sums  (s_sums),
        .i_width (s_width),
        .o_valid (s_valid),
        .o_avg   (s_avg),
        .o_gau   (s_gau),
        .o_last  (s_last)
    );

    assign o_result.valid       = s_valid;
    assign o_result.avg_red     = s_avg[0];
    assign o_result.avg_green   = s_avg[1];
    assign o_result.avg_blue    = s_avg[2];
    assign o_result.gauss_red   = s_gau[0];
    assign o_result.gauss_green = s_gau[1];
    assign o_result.gauss_blue  = s_gau[2];
    assign o_result.frame_end   = s_last;
endmodule
